// File: design/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// wsfd_pkg
// shared types and constants of the websocket frame deframer
// ----------------------------------------------------------------------------
package wsfd_pkg;

    localparam int LENGTH_BITS = 64;
    localparam int CMP_W       = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // opcodes of the first header byte
    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    // frame kinds
    localparam logic [2:0] KIND_TEXT  = 3'd0;
    localparam logic [2:0] KIND_BIN   = 3'd1;
    localparam logic [2:0] KIND_CLOSE = 3'd2;
    localparam logic [2:0] KIND_PING  = 3'd3;
    localparam logic [2:0] KIND_PONG  = 3'd4;

    // error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_PROTO = 2'd1;
    localparam logic [1:0] ERR_SIZE  = 2'd2;

    // length codes
    localparam logic [6:0] LEN_CODE_16 = 7'h7E;
    localparam logic [6:0] LEN_CODE_64 = 7'h7F;

    // configuration register indexes
    localparam logic [7:0] CFG_SERVER_MODE  = 8'd0;
    localparam logic [7:0] CFG_LENGTH_LIMIT = 8'd1;

    typedef enum logic [2:0] {
        PH_HEAD,
        PH_LEN,
        PH_EXLEN,
        PH_KEY,
        PH_DATA
    } wsfd_phase_t;

    // classified item passed from the parser to the output side
    typedef struct packed {
        logic [7:0] rx_byte;
        logic [7:0] key_byte;
        logic       payload_valid;
        logic       frame_done;
        logic [2:0] frame_kind;
        logic       final_bit;
        logic [1:0] error_code;
    } wsfd_item_t;

endpackage

// File: design/wsfd_front.sv
// ----------------------------------------------------------------------------
// wsfd_front
// frame parser: takes one byte per cycle unless the queue is full, tracks
// header, length, key and payload position and classifies each byte into a result item
// ----------------------------------------------------------------------------
module wsfd_front
    import wsfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        cfg_valid,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        queue_full,
    output logic        push,
    output wsfd_item_t  push_item
);

    wsfd_phase_t            phase_reg, phase_next;
    logic [2:0]             kind_reg, kind_next;
    logic                   fin_reg, fin_next;
    logic                   masked_reg, masked_next;
    logic [6:0]             code_reg, code_next;
    logic [LENGTH_BITS-1:0] plen_reg, plen_next;
    logic [3:0]             lcnt_reg, lcnt_next;
    logic [31:0]            key_reg, key_next;
    logic [2:0]             kcnt_reg, kcnt_next;
    logic [LENGTH_BITS-1:0] pcnt_reg, pcnt_next;
    logic                   server_mode_reg;
    logic [31:0]            limit_reg;

    logic                   accept;
    logic [LENGTH_BITS-1:0] pcnt_inc;
    logic [CMP_W-1:0]       plen_ext;
    logic [CMP_W-1:0]       limit_ext;
    logic                   size_err;
    logic [7:0]             key_sel;
    logic                   pvalid;
    logic                   done;
    logic [1:0]             err;

    assign in_ready  = !queue_full;
    assign accept    = in_valid && !queue_full;
    assign pcnt_inc  = pcnt_reg + LENGTH_BITS'(1);
    assign plen_ext  = CMP_W'(plen_reg);
    assign limit_ext = CMP_W'(limit_reg);
    assign size_err  = (plen_ext >= limit_ext);

    always_comb begin
        case (pcnt_reg[1:0])
            2'd0:    key_sel = key_reg[31:24];
            2'd1:    key_sel = key_reg[23:16];
            2'd2:    key_sel = key_reg[15:8];
            default: key_sel = key_reg[7:0];
        endcase
    end

    always_comb begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        fin_next    = fin_reg;
        masked_next = masked_reg;
        code_next   = code_reg;
        plen_next   = plen_reg;
        lcnt_next   = lcnt_reg;
        key_next    = key_reg;
        kcnt_next   = kcnt_reg;
        pcnt_next   = pcnt_reg;
        pvalid      = 1'b0;
        done        = 1'b0;
        err         = ERR_NONE;
        case (phase_reg)
            PH_HEAD: begin
                lcnt_next = '0;
                plen_next = '0;
                key_next  = '0;
                kcnt_next = '0;
                pcnt_next = '0;
                fin_next  = in_byte[7];
                case (in_byte[3:0])
                    OP_CONT:  kind_next = kind_reg;
                    OP_TEXT:  kind_next = KIND_TEXT;
                    OP_BIN:   kind_next = KIND_BIN;
                    OP_CLOSE: kind_next = KIND_CLOSE;
                    OP_PING:  kind_next = KIND_PING;
                    OP_PONG:  kind_next = KIND_PONG;
                    default:  err       = ERR_PROTO;
                endcase
                if (err == ERR_NONE) begin
                    phase_next = PH_LEN;
                end
            end
            PH_LEN: begin
                masked_next = in_byte[7];
                code_next   = in_byte[6:0];
                if (server_mode_reg && !in_byte[7]) begin
                    err        = ERR_PROTO;
                    phase_next = PH_HEAD;
                end else if (in_byte[6:0] < LEN_CODE_16) begin
                    plen_next = LENGTH_BITS'(in_byte[6:0]);
                    if (in_byte[7]) begin
                        phase_next = PH_KEY;
                    end else if (in_byte[6:0] == 7'd0) begin
                        done       = 1'b1;
                        phase_next = PH_HEAD;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end else begin
                    phase_next = PH_EXLEN;
                end
            end
            PH_EXLEN: begin
                lcnt_next = lcnt_reg + 4'd1;
                plen_next = {plen_reg[LENGTH_BITS-9:0], in_byte};
                if ((code_reg == LEN_CODE_16 && lcnt_next == 4'd2) ||
                    (code_reg == LEN_CODE_64 && lcnt_next == 4'd8)) begin
                    if (masked_reg) begin
                        phase_next = PH_KEY;
                    end else if (plen_next == '0) begin
                        done       = 1'b1;
                        phase_next = PH_HEAD;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_KEY: begin
                key_next  = {key_reg[23:0], in_byte};
                kcnt_next = kcnt_reg + 3'd1;
                if (kcnt_next[2]) begin
                    if (plen_reg == '0) begin
                        done       = 1'b1;
                        phase_next = PH_HEAD;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                if (size_err) begin
                    err        = ERR_SIZE;
                    phase_next = PH_HEAD;
                end else begin
                    pvalid    = 1'b1;
                    pcnt_next = pcnt_inc;
                    if (pcnt_inc == plen_reg) begin
                        done       = 1'b1;
                        phase_next = PH_HEAD;
                    end
                end
            end
            default: begin
                phase_next = PH_HEAD;
            end
        endcase
    end

    assign push                    = accept;
    assign push_item.rx_byte       = in_byte;
    assign push_item.key_byte      = masked_reg ? key_sel : 8'd0;
    assign push_item.payload_valid = pvalid;
    assign push_item.frame_done    = done;
    assign push_item.frame_kind    = kind_next;
    assign push_item.final_bit     = fin_next;
    assign push_item.error_code    = err;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEAD;
            kind_reg   <= KIND_TEXT;
            fin_reg    <= 1'b0;
            masked_reg <= 1'b0;
            code_reg   <= '0;
            plen_reg   <= '0;
            lcnt_reg   <= '0;
            key_reg    <= '0;
            kcnt_reg   <= '0;
            pcnt_reg   <= '0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            fin_reg    <= fin_next;
            masked_reg <= masked_next;
            code_reg   <= code_next;
            plen_reg   <= plen_next;
            lcnt_reg   <= lcnt_next;
            key_reg    <= key_next;
            kcnt_reg   <= kcnt_next;
            pcnt_reg   <= pcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            server_mode_reg <= 1'b0;
            limit_reg       <= 32'hFFFF_FFFF;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_SERVER_MODE) begin
                server_mode_reg <= cfg_data[0];
            end else if (cfg_index == CFG_LENGTH_LIMIT) begin
                limit_reg <= cfg_data;
            end
        end
    end

endmodule

// File: design/wsfd_queue.sv
// ----------------------------------------------------------------------------
// wsfd_queue
// short item queue between parser and output stage
// ----------------------------------------------------------------------------
module wsfd_queue
    import wsfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  wsfd_item_t push_item,
    output logic       full,
    input  logic       pop,
    output logic       not_empty,
    output wsfd_item_t pop_item
);

    wsfd_item_t        mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// File: design/wsfd_back.sv
// ----------------------------------------------------------------------------
// wsfd_back
// output stage: unmasks payload bytes and holds the result item until taken
// ----------------------------------------------------------------------------
module wsfd_back
    import wsfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  wsfd_item_t in_item,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic [6:0] m_tuser
);

    logic       valid_reg;
    logic [7:0] data_reg;
    logic       last_reg;
    logic [6:0] user_reg;
    logic [7:0] data_next;

    assign pop       = in_valid && (!valid_reg || m_tready);
    assign data_next = in_item.payload_valid ? (in_item.rx_byte ^ in_item.key_byte) : 8'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            data_reg <= data_next;
            last_reg <= in_item.frame_done;
            user_reg <= {in_item.error_code, in_item.final_bit, in_item.frame_kind,
                         in_item.payload_valid};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

endmodule

// File: design/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// byte-serial websocket frame parser with payload unmasking
//
// channel   | direction | contents
// s_        | in        | tdata[7:0] rx_byte
// m_        | out       | tdata[7:0] payload_byte, tlast frame_done,
//           |           | tuser[0] payload_valid, [3:1] frame_kind,
//           |           | [4] final_bit, [6:5] error_code
// cfg_      | in        | index 0 server_mode, index 1 length_limit
//
// one item per cycle sustained while m_tready holds; each byte is parsed in the
// cycle it is taken, and its result is registered in a two-entry queue and
// then in the output register
// aresetn is synchronous; no clearing pass, the block takes items right away
// s_tready drops only when the queue is full under an m_tready stall
// ----------------------------------------------------------------------------
module websocket_frame_deframer
    import wsfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] payload_byte
    output logic        m_tlast,
    output logic [6:0]  m_tuser,    // [0] payload_valid, [3:1] frame_kind,
                                    // [4] final_bit, [6:5] error_code
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic       push;
    wsfd_item_t push_item;
    logic       full;
    logic       pop;
    logic       not_empty;
    wsfd_item_t pop_item;

    assign cfg_ready = 1'b1;

    wsfd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (full),
        .push       (push),
        .push_item  (push_item)
    );

    wsfd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_item  (pop_item)
    );

    wsfd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (not_empty),
        .in_item  (pop_item),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// File: design/wsfd_checker.sv
// ----------------------------------------------------------------------------
// wsfd_checker
// port-level checks of the deframer, bound to the top level
// ----------------------------------------------------------------------------
module wsfd_checker
    import wsfd_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [6:0] m_tuser
);

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result item shown after reset");

    // a stalled item holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("stalled item changed");

    // non-payload items carry a zero byte
    a_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
        else $error("non-payload item with data");

    // an error item is neither payload nor frame end
    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[6:5] != ERR_NONE) |-> !m_tuser[0] && !m_tlast)
        else $error("error item marked payload or last");

endmodule

bind websocket_frame_deframer wsfd_checker u_wsfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// File: tb/websocket_frame_deframer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_tb
// self-checking bench for the byte-serial websocket frame parser
//
// A behavioral parser inside the bench follows every accepted byte and queues
// the result it must produce. Results from the block are compared field by
// field in order. Directed frames cover every opcode, the length encodings,
// masking, zero-length frames and the error cases. Random traffic then mixes
// well-formed frames with noise and cut-off frames under several
// configurations and idle patterns, including one long output stall.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_tb;
    import wsfd_pkg::*;

    localparam int         CYCLE_LIMIT = 400_000;
    localparam logic [7:0] CFG_NO_REG  = 8'd7;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       frame_done;
        logic [2:0] frame_kind;
        logic       final_bit;
        logic [1:0] error_code;
    } parse_result_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;     // [7:0] payload_byte
    logic        m_tlast;
    logic [6:0]  m_tuser;     // [0] payload_valid, [3:1] frame_kind, [4] final_bit,
                              // [6:5] error_code
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = 8'h00;
    logic [31:0] cfg_data  = 32'h0;

    // parser state as the bench sees it
    wsfd_phase_t            rx_phase;
    logic [2:0]             cur_kind;
    logic                   cur_fin;
    logic                   cur_masked;
    logic [6:0]             len_code;
    logic [LENGTH_BITS-1:0] frame_len;
    logic [3:0]             ext_len_count;
    logic [31:0]            mask_word;
    logic [2:0]             key_count;
    logic [LENGTH_BITS-1:0] data_count;
    logic                   cfg_server;
    logic [31:0]            cfg_limit;

    parse_result_t parse_results[$];
    int            mismatch_count = 0;
    int            bytes_sent     = 0;
    int            cycle_count    = 0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            recv_hold      = 0;

    websocket_frame_deframer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("websocket_frame_deframer verification failed");
            $finish;
        end
    end

    // receiver: random stalls plus an optional long hold-off
    always @(posedge aclk) begin
        if (recv_hold > 0) begin
            m_tready <= 1'b0;
            recv_hold <= recv_hold - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic clear_parser();
        rx_phase      = PH_HEAD;
        cur_kind      = KIND_TEXT;
        cur_fin       = 1'b0;
        cur_masked    = 1'b0;
        len_code      = '0;
        frame_len     = '0;
        ext_len_count = '0;
        mask_word     = '0;
        key_count     = '0;
        data_count    = '0;
        cfg_server    = 1'b0;
        cfg_limit     = 32'hFFFF_FFFF;
    endtask

    function automatic logic header_complete();
        if (cur_masked) begin
            rx_phase = PH_KEY;
            return 1'b0;
        end
        if (frame_len == 0) begin
            rx_phase = PH_HEAD;
            return 1'b1;
        end
        rx_phase = PH_DATA;
        return 1'b0;
    endfunction

    function automatic parse_result_t parse_rx_byte(input logic [7:0] rx);
        parse_result_t r;
        logic [7:0]    b;
        r = '0;
        b = rx;
        case (rx_phase)
            PH_HEAD: begin
                ext_len_count = '0;
                frame_len     = '0;
                mask_word     = '0;
                key_count     = '0;
                data_count    = '0;
                cur_fin       = b[7];
                case (b[3:0])
                    OP_CONT:  ;
                    OP_TEXT:  cur_kind = KIND_TEXT;
                    OP_BIN:   cur_kind = KIND_BIN;
                    OP_CLOSE: cur_kind = KIND_CLOSE;
                    OP_PING:  cur_kind = KIND_PING;
                    OP_PONG:  cur_kind = KIND_PONG;
                    default:  r.error_code = ERR_PROTO;
                endcase
                if (r.error_code == ERR_NONE) rx_phase = PH_LEN;
            end
            PH_LEN: begin
                cur_masked = b[7];
                len_code   = b[6:0];
                if (cfg_server && !cur_masked) begin
                    r.error_code = ERR_PROTO;
                    rx_phase = PH_HEAD;
                end else if (len_code < LEN_CODE_16) begin
                    frame_len = LENGTH_BITS'(len_code);
                    r.frame_done = header_complete();
                end else begin
                    rx_phase = PH_EXLEN;
                end
            end
            PH_EXLEN: begin
                ext_len_count = ext_len_count + 4'd1;
                frame_len = {frame_len[LENGTH_BITS-9:0], b};
                if ((len_code == LEN_CODE_16 && ext_len_count == 4'd2) ||
                    (len_code == LEN_CODE_64 && ext_len_count == 4'd8))
                    r.frame_done = header_complete();
            end
            PH_KEY: begin
                mask_word = {mask_word[23:0], b};
                key_count = key_count + 3'd1;
                if (key_count >= 3'd4) begin
                    if (frame_len == 0) begin
                        r.frame_done = 1'b1;
                        rx_phase = PH_HEAD;
                    end else begin
                        rx_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                if (frame_len >= LENGTH_BITS'(cfg_limit)) begin
                    r.error_code = ERR_SIZE;
                    rx_phase = PH_HEAD;
                end else begin
                    if (cur_masked) b = b ^ mask_word[8*(3 - data_count[1:0]) +: 8];
                    r.payload_byte  = b;
                    r.payload_valid = 1'b1;
                    data_count = data_count + LENGTH_BITS'(1);
                    if (data_count == frame_len) begin
                        r.frame_done = 1'b1;
                        rx_phase = PH_HEAD;
                    end
                end
            end
            default: rx_phase = PH_HEAD;
        endcase
        r.frame_kind = cur_kind;
        r.final_bit  = cur_fin;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("[%0t] %s: got 0x%0h expected 0x%0h", $time, what, got, want);
    endtask

    always @(posedge aclk) begin
        parse_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (parse_results.size() == 0) begin
                report_mismatch("item with nothing expected",
                                64'({m_tuser, m_tlast, m_tdata}), 64'd0);
            end else begin
                want = parse_results.pop_front();
                if (m_tdata !== want.payload_byte)
                    report_mismatch("payload_byte", 64'(m_tdata), 64'(want.payload_byte));
                if (m_tuser[0] !== want.payload_valid)
                    report_mismatch("payload_valid", 64'(m_tuser[0]),
                                    64'(want.payload_valid));
                if (m_tlast !== want.frame_done)
                    report_mismatch("frame_done", 64'(m_tlast), 64'(want.frame_done));
                if (m_tuser[3:1] !== want.frame_kind)
                    report_mismatch("frame_kind", 64'(m_tuser[3:1]), 64'(want.frame_kind));
                if (m_tuser[4] !== want.final_bit)
                    report_mismatch("final_bit", 64'(m_tuser[4]), 64'(want.final_bit));
                if (m_tuser[6:5] !== want.error_code)
                    report_mismatch("error_code", 64'(m_tuser[6:5]), 64'(want.error_code));
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        parse_results.push_back(parse_rx_byte(b));
        bytes_sent++;
    endtask

    task automatic send_bytes(input logic [7:0] seq []);
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (parse_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_SERVER_MODE:  cfg_server = val[0];
            CFG_LENGTH_LIMIT: cfg_limit  = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic srv, input logic [31:0] lim);
        wait_idle();
        write_reg(CFG_SERVER_MODE, {31'($urandom), srv});
        write_reg(CFG_NO_REG, $urandom);
        write_reg(CFG_LENGTH_LIMIT, lim);
        cfg_valid <= 1'b0;
    endtask

    // bring the parser back to a header boundary after noise or a cut frame
    task automatic realign_parser();
        while (rx_phase != PH_HEAD) begin
            case (rx_phase)
                PH_LEN:   send_byte({1'($urandom), 7'h00});
                PH_EXLEN: send_byte(8'h00);
                PH_DATA: begin
                    if (frame_len - data_count > 64 && frame_len < LENGTH_BITS'(cfg_limit))
                        set_config(cfg_server, frame_len[31:0]);
                    else
                        send_byte(8'($urandom));
                end
                default:  send_byte(8'($urandom));
            endcase
        end
    endtask

    task automatic send_frame();
        logic [7:0]  frame_q[$];
        logic [3:0]  op;
        logic [63:0] len;
        logic [6:0]  code;
        logic        msk;
        int          pick;
        int          enc;
        int          nb;
        int          keep;
        if ($urandom_range(99) < 5) begin
            do op = 4'($urandom);
            while (op == OP_CONT || op == OP_TEXT || op == OP_BIN || op == OP_CLOSE ||
                   op == OP_PING || op == OP_PONG);
            send_byte({1'($urandom), 3'($urandom), op});
            return;
        end
        case ($urandom_range(5))
            0:       op = OP_CONT;
            1:       op = OP_TEXT;
            2:       op = OP_BIN;
            3:       op = OP_CLOSE;
            4:       op = OP_PING;
            default: op = OP_PONG;
        endcase
        msk  = cfg_server ? ($urandom_range(9) != 0) : 1'($urandom);
        pick = $urandom_range(99);
        if (pick < 8)
            len = 64'd0;
        else if (pick < 72)
            len = 64'($urandom_range(1, 20));
        else if (pick < 78)
            len = 64'($urandom_range(100, 200));
        else if (pick < 90)
            len = ($urandom_range(3) == 0) ? '1
                                           : {32'b0, cfg_limit} + 64'($urandom_range(0, 5));
        else
            len = 64'($urandom_range(0, 20));
        enc = (len < 126) ? 0 : (len <= 64'hFFFF) ? 1 : 2;
        if (pick >= 90) enc = $urandom_range(1, 2);
        code = (enc == 0) ? len[6:0] : (enc == 1) ? LEN_CODE_16 : LEN_CODE_64;
        nb   = (enc == 0) ? 0 : (enc == 1) ? 2 : 8;
        frame_q.push_back({1'($urandom), 3'($urandom), op});
        frame_q.push_back({msk, code});
        if (!cfg_server || msk) begin
            for (int i = nb - 1; i >= 0; i--) frame_q.push_back(len[8*i +: 8]);
            if (msk) repeat (4) frame_q.push_back(8'($urandom));
            if (len != 0) begin
                if (len >= {32'b0, cfg_limit})
                    frame_q.push_back(8'($urandom));
                else
                    repeat (int'(len)) frame_q.push_back(8'($urandom));
            end
        end
        keep = frame_q.size();
        if ($urandom_range(99) < 6) keep = $urandom_range(1, frame_q.size() - 1);
        for (int i = 0; i < keep; i++) send_byte(frame_q[i]);
    endtask

    task automatic test_directed();
        send_bytes('{8'h81, 8'h00,
                     8'h00, 8'h01, 8'hFF,
                     8'h8B,
                     8'h82, 8'h82, 8'hA5, 8'h5A, 8'hFF, 8'h00, 8'h00, 8'hFF,
                     8'h89, 8'h7E, 8'h00, 8'h01, 8'h00,
                     8'h8A, 8'h00,
                     8'h08, 8'h00});
    endtask

    task automatic test_config_cases();
        // server side: unmasked rejected, masked empty frame completes on key
        set_config(1'b1, 32'hFFFF_FFFF);
        send_bytes('{8'h81, 8'h05,
                     8'h88, 8'h80, 8'h01, 8'h02, 8'h03, 8'h04});
        // zero limit drops the first payload byte
        set_config(1'b0, 32'h0);
        send_bytes('{8'h82, 8'h01, 8'h33});
        // largest 64-bit length against the widest limit
        set_config(1'b0, 32'hFFFF_FFFF);
        send_bytes('{8'h82, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h44});
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int hold);
        int          stop_at;
        int          pick;
        logic [31:0] lim;
        pick = $urandom_range(9);
        if (pick < 4)
            lim = 32'hFFFF_FFFF;
        else if (pick == 4)
            lim = 32'h0;
        else if (pick < 8)
            lim = $urandom_range(1, 30);
        else
            lim = $urandom;
        set_config(1'($urandom), lim);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        if (hold > 0) recv_hold <= hold;
        stop_at = bytes_sent + 220;
        while (bytes_sent < stop_at) begin
            realign_parser();
            if ($urandom_range(99) < 6)
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            send_frame();
        end
    endtask

    initial begin
        clear_parser();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_config_cases();
        test_random_traffic(0, 0, 300);
        test_random_traffic(81, 0, 0);
        test_random_traffic(0, 81, 0);
        test_random_traffic(7, 7, 0);
        wait_idle();
        if (mismatch_count == 0 && parse_results.size() == 0) begin
            $display("websocket_frame_deframer verification clean");
        end else begin
            $display("websocket_frame_deframer verification failed");
        end
        $finish;
    end

endmodule
